// ----- hdl/tpc_pkg.sv -----
// shared types, constants and helpers for the temperature and pressure compensation block
// no dependencies; used by every module in hdl
`default_nettype none
package tpc_pkg;

	localparam logic [31:0] OFFSET_FINE = 32'd64000;
	localparam logic [31:0] PRESS_BASE  = 32'd1048576;
	localparam logic [31:0] PRESS_SCALE = 32'd3125;
	localparam logic [31:0] DIV_BIAS    = 32'd32768;
	localparam logic [31:0] ROUND_HALF  = 32'd128;
	localparam logic [31:0] TEMP_MUL    = 32'd5;
	localparam int          DIV_STAGES  = 32;

	// register indexes of the configuration port
	localparam logic [3:0] REG_T1     = 4'd0;
	localparam logic [3:0] REG_T2     = 4'd1;
	localparam logic [3:0] REG_T3     = 4'd2;
	localparam logic [3:0] REG_P1     = 4'd3;
	localparam logic [3:0] REG_P2_P4  = 4'd4;
	localparam logic [3:0] REG_P5_P6  = 4'd5;
	localparam logic [3:0] REG_P7_P8  = 4'd6;
	localparam logic [3:0] REG_P9     = 4'd7;

	// calibration set as seen by the datapath
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coef_t;

	// temperature results and pressure status riding along the pressure path
	typedef struct packed {
		logic [15:0] cent;
		logic [31:0] fine;
		logic        pvalid;
		logic        post;
	} side_t;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

	// sign-extend a 16-bit coefficient
	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

// ----- hdl/tpc_temp.sv -----
// temperature compensation stages one to four, producing the fine temperature
// depends on tpc_pkg
`default_nettype none
module tpc_temp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire tpc_pkg::coef_t coef,
	input  wire logic          vin,
	input  wire logic [19:0]   raw_t,
	input  wire logic [19:0]   raw_p,
	output logic               vout,
	output logic [31:0]        fine,
	output logic [19:0]        rp
);
	logic [3:0]  v_s;
	logic [31:0] x1_s1, d_s1;
	logic [31:0] a0_s2, dd_s2;
	logic [31:0] a_s3, b0_s3;
	logic [31:0] fine_s4;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4;
	logic [31:0] t1x;

	assign t1x = {16'd0, coef.t1};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[2:0], vin};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= {15'd0, raw_t[19:3]} - {t1x[30:0], 1'b0};
			d_s1    <= {16'd0, raw_t[19:4]} - t1x;
			rp_s1   <= raw_p;
			a0_s2   <= x1_s1 * tpc_pkg::sx16(coef.t2);
			dd_s2   <= d_s1 * d_s1;
			rp_s2   <= rp_s1;
			a_s3    <= tpc_pkg::asr(a0_s2, 5'd11);
			b0_s3   <= tpc_pkg::asr(dd_s2, 5'd12) * tpc_pkg::sx16(coef.t3);
			rp_s3   <= rp_s2;
			fine_s4 <= a_s3 + tpc_pkg::asr(b0_s3, 5'd14);
			rp_s4   <= rp_s3;
		end
	end

	assign vout = v_s[3];
	assign fine = fine_s4;
	assign rp   = rp_s4;
endmodule
`default_nettype wire

// ----- hdl/tpc_press_pre.sv -----
// pressure stages five to eleven: offsets, divisor and dividend set-up
// depends on tpc_pkg
`default_nettype none
module tpc_press_pre (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire tpc_pkg::coef_t coef,
	input  wire logic           vin,
	input  wire logic [31:0]    fine,
	input  wire logic [19:0]    rp,
	output logic                vout,
	output logic [31:0]         dvd,
	output logic [31:0]         dvs,
	output tpc_pkg::side_t      side
);
	logic [6:0]  v_s;
	logic [31:0] cp_s5, pa_s5;
	logic [31:0] sq_s6, ap5_s6, p2a_s6;
	logic [31:0] b6_s7, p3s_s7, ap5_s7, p2a_s7;
	logic [31:0] b_s8, a_s8;
	logic [31:0] a2_s9, nb_s9;
	logic [31:0] dvs_s10, num_s10;
	logic [31:0] dvd_s11, dvs_s11;
	logic [31:0] fine_s5, fine_s6, fine_s7, fine_s8, fine_s9, fine_s10, fine_s11;
	logic [15:0] cent_s6, cent_s7, cent_s8, cent_s9, cent_s10, cent_s11;
	logic [19:0] rp_s5, rp_s6, rp_s7, rp_s8;
	logic        post_s11, pv_s11;
	logic [31:0] q5;

	assign q5 = tpc_pkg::asr(pa_s5, 5'd2);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[5:0], vin};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			cp_s5    <= fine * tpc_pkg::TEMP_MUL + tpc_pkg::ROUND_HALF;
			pa_s5    <= tpc_pkg::asr(fine, 5'd1) - tpc_pkg::OFFSET_FINE;
			fine_s5  <= fine;
			rp_s5    <= rp;

			cent_s6  <= 16'(tpc_pkg::asr(cp_s5, 5'd8));
			sq_s6    <= q5 * q5;
			ap5_s6   <= pa_s5 * tpc_pkg::sx16(coef.p5);
			p2a_s6   <= tpc_pkg::sx16(coef.p2) * pa_s5;
			fine_s6  <= fine_s5;
			rp_s6    <= rp_s5;

			b6_s7    <= tpc_pkg::asr(sq_s6, 5'd11) * tpc_pkg::sx16(coef.p6);
			p3s_s7   <= tpc_pkg::sx16(coef.p3) * tpc_pkg::asr(sq_s6, 5'd13);
			ap5_s7   <= ap5_s6;
			p2a_s7   <= p2a_s6;
			cent_s7  <= cent_s6;
			fine_s7  <= fine_s6;
			rp_s7    <= rp_s6;

			b_s8     <= tpc_pkg::asr(b6_s7 + {ap5_s7[30:0], 1'b0}, 5'd2)
				+ {coef.p4, 16'd0};
			a_s8     <= tpc_pkg::asr(tpc_pkg::asr(p3s_s7, 5'd3)
				+ tpc_pkg::asr(p2a_s7, 5'd1), 5'd18);
			cent_s8  <= cent_s7;
			fine_s8  <= fine_s7;
			rp_s8    <= rp_s7;

			a2_s9    <= (tpc_pkg::DIV_BIAS + a_s8) * {16'd0, coef.p1};
			nb_s9    <= (tpc_pkg::PRESS_BASE - {12'd0, rp_s8}) - tpc_pkg::asr(b_s8, 5'd12);
			cent_s9  <= cent_s8;
			fine_s9  <= fine_s8;

			dvs_s10  <= tpc_pkg::asr(a2_s9, 5'd15);
			num_s10  <= nb_s9 * tpc_pkg::PRESS_SCALE;
			cent_s10 <= cent_s9;
			fine_s10 <= fine_s9;

			// small numerators are doubled before the divide, large ones after
			dvd_s11  <= num_s10[31] ? num_s10 : {num_s10[30:0], 1'b0};
			post_s11 <= num_s10[31];
			pv_s11   <= (dvs_s10 != 32'd0);
			dvs_s11  <= dvs_s10;
			cent_s11 <= cent_s10;
			fine_s11 <= fine_s10;
		end
	end

	assign vout        = v_s[6];
	assign dvd         = dvd_s11;
	assign dvs         = dvs_s11;
	assign side.cent   = cent_s11;
	assign side.fine   = fine_s11;
	assign side.pvalid = pv_s11;
	assign side.post   = post_s11;
endmodule
`default_nettype wire

// ----- hdl/tpc_div.sv -----
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
// depends on tpc_pkg
`default_nettype none
module tpc_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vin,
	input  wire logic [31:0]    dvd,
	input  wire logic [31:0]    dvs,
	input  wire tpc_pkg::side_t side_in,
	output logic                vout,
	output logic [31:0]         pres,
	output tpc_pkg::side_t      side_out
);
	localparam int N = tpc_pkg::DIV_STAGES;

	logic [N-1:0]   v_s;
	logic [31:0]    rem_s [N];
	logic [31:0]    num_s [N];
	logic [31:0]    quo_s [N];
	logic [31:0]    dvs_s [N];
	tpc_pkg::side_t side_s [N];
	logic [31:0]    rem_n [N];
	logic [N-1:0]   qbit_n;

	// trial subtract for each stage
	always_comb begin
		logic [32:0] r;
		for (int k = 0; k < N; k++) begin
			if (k == 0) r = {32'd0, dvd[31]};
			else        r = {rem_s[k-1], num_s[k-1][31]};
			if (r >= {1'b0, (k == 0) ? dvs : dvs_s[k-1]}) begin
				rem_n[k]  = 32'(r - {1'b0, (k == 0) ? dvs : dvs_s[k-1]});
				qbit_n[k] = 1'b1;
			end else begin
				rem_n[k]  = r[31:0];
				qbit_n[k] = 1'b0;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], vin};
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem_n[0];
			num_s[0]  <= {dvd[30:0], 1'b0};
			quo_s[0]  <= {31'd0, qbit_n[0]};
			dvs_s[0]  <= dvs;
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				rem_s[k]  <= rem_n[k];
				num_s[k]  <= {num_s[k-1][30:0], 1'b0};
				quo_s[k]  <= {quo_s[k-1][30:0], qbit_n[k]};
				dvs_s[k]  <= dvs_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// zero divisor forces zero, large numerators double the quotient
	always_comb begin
		if (!side_s[N-1].pvalid)   pres = 32'd0;
		else if (side_s[N-1].post) pres = {quo_s[N-1][30:0], 1'b0};
		else                       pres = quo_s[N-1];
	end

	assign vout     = v_s[N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

// ----- hdl/tpc_press_post.sv -----
// final pressure correction stages and the output register
// depends on tpc_pkg
`default_nettype none
module tpc_press_post (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire tpc_pkg::coef_t coef,
	input  wire logic           vin,
	input  wire logic [31:0]    pres,
	input  wire tpc_pkg::side_t side,
	output logic                vout,
	output logic [15:0]         cent,
	output logic [31:0]         fine,
	output logic [31:0]         press,
	output logic                pvalid
);
	logic [2:0]  v_s;
	logic [31:0] p_s1, u_s1, w_s1;
	logic [31:0] p_s2, m_s2, b_s2;
	logic [31:0] p_s3;
	tpc_pkg::side_t sd_s1, sd_s2, sd_s3;
	logic [31:0] p3x;

	assign p3x = {3'd0, pres[31:3]};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1:0], vin};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= pres;
			u_s1  <= p3x * p3x;
			w_s1  <= {2'd0, pres[31:2]} * tpc_pkg::sx16(coef.p8);
			sd_s1 <= side;

			p_s2  <= p_s1;
			m_s2  <= tpc_pkg::sx16(coef.p9) * {13'd0, u_s1[31:13]};
			b_s2  <= tpc_pkg::asr(w_s1, 5'd13);
			sd_s2 <= sd_s1;

			p_s3  <= sd_s2.pvalid
				? p_s2 + tpc_pkg::asr(tpc_pkg::asr(m_s2, 5'd12) + b_s2
					+ tpc_pkg::sx16(coef.p7), 5'd4)
				: 32'd0;
			sd_s3 <= sd_s2;
		end
	end

	assign vout   = v_s[2];
	assign cent   = sd_s3.cent;
	assign fine   = sd_s3.fine;
	assign press  = p_s3;
	assign pvalid = sd_s3.pvalid;
endmodule
`default_nettype wire

// ----- hdl/temp_pressure_compensation.sv -----
// top level: calibration registers and the compensation pipeline
// depends on tpc_pkg, tpc_temp, tpc_press_pre, tpc_div, tpc_press_post
`default_nettype none
// Raw temperature and pressure pairs go in, one per clock at full rate; each result
// passes through 4 temperature stages, 7 pressure set-up stages, 32 divider stages
// of one quotient bit each and 3 correction stages, the last of which is the
// output register. The whole pipeline advances together and holds while a finished
// result waits, so throughput is one item per cycle whenever
// out_ready is high. Calibration is written through cfg_we/cfg_index/cfg_data and
// must only change while no item is in flight; a zero pressure divisor gives
// pressure_pa of zero with pressure_valid low.
module temp_pressure_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [19:0] raw_pressure,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      temperature_centi,
	output logic [31:0]      fine_temperature,
	output logic [31:0]      pressure_pa,
	output logic             pressure_valid
);
	tpc_pkg::coef_t coef_q;
	tpc_pkg::side_t pre_side, div_side;
	logic        en;
	logic        v_t, v_pre, v_div;
	logic [31:0] fine_t, dvd, dvs, pres;
	logic [19:0] rp_t;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpc_pkg::REG_T1:    coef_q.t1 <= cfg_data[15:0];
				tpc_pkg::REG_T2:    coef_q.t2 <= cfg_data[15:0];
				tpc_pkg::REG_T3:    coef_q.t3 <= cfg_data[15:0];
				tpc_pkg::REG_P1:    coef_q.p1 <= cfg_data[15:0];
				tpc_pkg::REG_P2_P4: begin
					coef_q.p2 <= cfg_data[15:0];
					coef_q.p3 <= cfg_data[31:16];
					coef_q.p4 <= cfg_data[47:32];
				end
				tpc_pkg::REG_P5_P6: begin
					coef_q.p5 <= cfg_data[15:0];
					coef_q.p6 <= cfg_data[31:16];
				end
				tpc_pkg::REG_P7_P8: begin
					coef_q.p7 <= cfg_data[15:0];
					coef_q.p8 <= cfg_data[31:16];
				end
				tpc_pkg::REG_P9:    coef_q.p9 <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// fine temperature
	tpc_temp u_temp (
		.clk(clk), .arst_n(arst_n), .en(en), .coef(coef_q),
		.vin(in_valid && in_ready), .raw_t(raw_temperature), .raw_p(raw_pressure),
		.vout(v_t), .fine(fine_t), .rp(rp_t)
	);

	// pressure set-up
	tpc_press_pre u_pre (
		.clk(clk), .arst_n(arst_n), .en(en), .coef(coef_q),
		.vin(v_t), .fine(fine_t), .rp(rp_t),
		.vout(v_pre), .dvd(dvd), .dvs(dvs), .side(pre_side)
	);

	// divider
	tpc_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v_pre), .dvd(dvd), .dvs(dvs), .side_in(pre_side),
		.vout(v_div), .pres(pres), .side_out(div_side)
	);

	// correction and output register
	tpc_press_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en), .coef(coef_q),
		.vin(v_div), .pres(pres), .side(div_side),
		.vout(out_valid), .cent(temperature_centi), .fine(fine_temperature),
		.press(pressure_pa), .pvalid(pressure_valid)
	);
endmodule
`default_nettype wire

// ----- tb/sv/tb_temp_pressure_compensation.sv -----
// self-checking testbench for temp_pressure_compensation
// depends on tpc_pkg and the hdl sources; predicts each result and compares field by field
`default_nettype none
module tb_temp_pressure_compensation;

	typedef struct packed {
		logic [19:0] rt;
		logic [19:0] rp;
	} reading_t;

	typedef struct packed {
		logic [15:0] cent;
		logic [31:0] fine;
		logic [31:0] press;
		logic        pval;
	} comp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [19:0] raw_temperature = '0;
	logic [19:0] raw_pressure = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] temperature_centi;
	logic [31:0] fine_temperature;
	logic [31:0] pressure_pa;
	logic        pressure_valid;

	// calibration copy
	logic [15:0] cal_t1, cal_t2, cal_t3, cal_p1, cal_p9;
	logic [47:0] cal_p24;
	logic [31:0] cal_p56, cal_p78;

	reading_t pending_readings[$];
	comp_t    expected_comps[$];
	int       error_count = 0;
	int       in_gap = 0;
	int       out_gap = 0;
	int       in_draw;
	int       out_draw;

	temp_pressure_compensation i_dut (.*);

	always #6 clk = ~clk;

	function automatic logic [31:0] sar(input logic [31:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// compensation predictor
	function automatic comp_t compensate(input reading_t r);
		comp_t c;
		logic [31:0] a, b, d, sq, fine, p, rt, t1;
		rt = {12'd0, r.rt};
		t1 = {16'd0, cal_t1};
		a = sar(((rt >> 3) - (t1 << 1)) * sext(cal_t2), 11);
		d = (rt >> 4) - t1;
		b = sar(sar(d * d, 12) * sext(cal_t3), 14);
		fine = a + b;
		c.cent = 16'(sar(fine * 32'd5 + 32'd128, 8));
		c.fine = fine;
		a = sar(fine, 1) - 32'd64000;
		sq = sar(a, 2) * sar(a, 2);
		b = sar(sq, 11) * sext(cal_p56[31:16]);
		b = b + ((a * sext(cal_p56[15:0])) << 1);
		b = sar(b, 2) + (sext(cal_p24[47:32]) << 16);
		a = sar(sar(sext(cal_p24[31:16]) * sar(sq, 13), 3) + sar(sext(cal_p24[15:0]) * a, 1), 18);
		a = sar((32'd32768 + a) * {16'd0, cal_p1}, 15);
		if (a == 0) begin
			c.press = '0;
			c.pval = 1'b0;
		end else begin
			p = ((32'd1048576 - {12'd0, r.rp}) - sar(b, 12)) * 32'd3125;
			if (p < 32'h80000000)
				p = (p << 1) / a;
			else
				p = (p / a) * 32'd2;
			a = sar(sext(cal_p9) * (((p >> 3) * (p >> 3)) >> 13), 12);
			b = sar((p >> 2) * sext(cal_p78[31:16]), 13);
			p = p + sar(a + b + sext(cal_p78[15:0]), 4);
			c.press = p;
			c.pval = 1'b1;
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// driver: one transfer per queued reading, random gap before each
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_comps.push_back(compensate({raw_temperature, raw_pressure}));
			void'(pending_readings.pop_front());
			in_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (pending_readings.size() > 0 && in_draw == 0) begin
				raw_temperature <= pending_readings[0].rt;
				raw_pressure <= pending_readings[0].rp;
			end else begin
				in_valid <= 1'b0;
				in_gap <= (in_draw > 0) ? in_draw - 1 : 0;
			end
		end else if (!in_valid && pending_readings.size() > 0) begin
			if (in_gap > 0)
				in_gap <= in_gap - 1;
			else begin
				in_valid <= 1'b1;
				raw_temperature <= pending_readings[0].rt;
				raw_pressure <= pending_readings[0].rp;
			end
		end
	end

	// monitor: check each result transfer, stall ready at random
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_comps.size() == 0) begin
				$display("unexpected result transfer at %0t", $time);
				error_count++;
			end else begin
				comp_t w;
				w = expected_comps.pop_front();
				if (temperature_centi !== w.cent)
					report_mismatch("temperature_centi", {16'd0, temperature_centi}, {16'd0, w.cent});
				if (fine_temperature !== w.fine)
					report_mismatch("fine_temperature", fine_temperature, w.fine);
				if (pressure_pa !== w.press)
					report_mismatch("pressure_pa", pressure_pa, w.press);
				if (pressure_valid !== w.pval)
					report_mismatch("pressure_valid", {31'd0, pressure_valid}, {31'd0, w.pval});
			end
			out_draw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
			if (out_draw > 0) begin
				out_ready <= 1'b0;
				out_gap <= out_draw - 1;
			end
		end else if (out_gap > 0)
			out_gap <= out_gap - 1;
		else
			out_ready <= 1'b1;
	end

	task automatic write_reg(input logic [3:0] idx, input logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			tpc_pkg::REG_T1:    cal_t1 = val[15:0];
			tpc_pkg::REG_T2:    cal_t2 = val[15:0];
			tpc_pkg::REG_T3:    cal_t3 = val[15:0];
			tpc_pkg::REG_P1:    cal_p1 = val[15:0];
			tpc_pkg::REG_P2_P4: cal_p24 = val;
			tpc_pkg::REG_P5_P6: cal_p56 = val[31:0];
			tpc_pkg::REG_P7_P8: cal_p78 = val[31:0];
			tpc_pkg::REG_P9:    cal_p9 = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the pipeline to drain
	task automatic drain();
		while (pending_readings.size() > 0 || in_valid || expected_comps.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// typical sensor calibration with small per-set perturbation
	task automatic load_typical();
		write_reg(tpc_pkg::REG_T1, 48'd27504 + $urandom_range(0, 200));
		write_reg(tpc_pkg::REG_T2, 48'd26435);
		write_reg(tpc_pkg::REG_T3, 48'(16'(-1000)));
		write_reg(tpc_pkg::REG_P1, 48'd36477 + $urandom_range(0, 200));
		write_reg(tpc_pkg::REG_P2_P4, {16'd2855, 16'(-3*1000 - 24), 16'(-10685)});
		write_reg(tpc_pkg::REG_P5_P6, {16'(-7), 16'd140});
		write_reg(tpc_pkg::REG_P7_P8, {16'(-10230), 16'd15500});
		write_reg(tpc_pkg::REG_P9, 48'd4000 + $urandom_range(0, 2000));
	endtask

	task automatic load_random();
		for (int i = 0; i < 8; i++)
			write_reg(i[3:0], 48'({$urandom, $urandom}));
	endtask

	task automatic queue_random(input int n, input bit plausible);
		reading_t r;
		for (int i = 0; i < n; i++) begin
			if (plausible && $urandom_range(0, 4) != 0) begin
				r.rt = 20'($urandom_range(400000, 600000));
				r.rp = 20'($urandom_range(250000, 450000));
			end else begin
				r.rt = 20'($urandom);
				r.rp = 20'($urandom);
			end
			pending_readings.push_back(r);
		end
	endtask

	initial begin
		{cal_t1, cal_t2, cal_t3, cal_p1, cal_p9} = '0;
		cal_p24 = '0;
		cal_p56 = '0;
		cal_p78 = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// reset calibration: zero divisor
		pending_readings.push_back({20'd0, 20'd0});
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		drain();
		// directed extremes on typical calibration
		load_typical();
		pending_readings.push_back({20'd0, 20'd0});
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		pending_readings.push_back({20'd0, 20'hFFFFF});
		pending_readings.push_back({20'hFFFFF, 20'd0});
		pending_readings.push_back({20'd519888, 20'd415148});
		pending_readings.push_back({20'hAAAAA, 20'h55555});
		pending_readings.push_back({20'h55555, 20'hAAAAA});
		drain();
		// register extremes, bad index ignored
		write_reg(4'd8, '1);
		write_reg(4'd15, '0);
		for (int i = 0; i < 8; i++)
			write_reg(i[3:0], '1);
		pending_readings.push_back({20'd0, 20'd0});
		pending_readings.push_back({20'hFFFFF, 20'hFFFFF});
		pending_readings.push_back({20'h80000, 20'h7FFFF});
		drain();
		for (int i = 0; i < 8; i++)
			write_reg(i[3:0], {16'h8000, 16'h8000, 16'h8000});
		pending_readings.push_back({20'd0, 20'hFFFFF});
		pending_readings.push_back({20'hFFFFF, 20'd0});
		pending_readings.push_back({20'd500000, 20'd300000});
		drain();
		// random phases
		for (int ph = 0; ph < 14; ph++) begin
			if (ph % 3 == 2)
				load_random();
			else
				load_typical();
			if (ph == 5)
				write_reg(tpc_pkg::REG_P1, '0);
			queue_random(100, ph % 3 != 2);
			drain();
		end
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
